FILE: hdl/sspq_pkg.sv
`timescale 1ns / 1ps

package sspq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EC_W  = 5;

    localparam logic       CMD_PUSH  = 1'b0;
    localparam logic       CMD_POP   = 1'b1;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] item_value;
        logic        [7:0]  item_priority;
    } t_sspq_in;

    typedef struct packed {
        logic signed [31:0] front_value;
        logic               queue_empty;
        logic [EC_W-1:0]    entry_count;
        logic [1:0]         error_code;
    } t_sspq_out;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_sspq_ctrl;

endpackage

FILE: hdl/sspq_ctrl.sv
`timescale 1ns / 1ps

module sspq_ctrl
    import sspq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    output t_sspq_ctrl o_ctrl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy        = (r_state == ST_EXEC);
    assign o_ctrl.load = (r_state == ST_IDLE) && start;
    assign o_ctrl.exec = (r_state == ST_EXEC);

endmodule

FILE: hdl/sspq_dp.sv
`timescale 1ns / 1ps

module sspq_dp
    import sspq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_sspq_ctrl i_ctrl,
    input  t_sspq_in   i_item,
    output logic       o_strobe,
    output t_sspq_out  o_result
);

    t_sspq_in           r_item;
    logic signed [31:0] r_val [DEPTH];
    logic        [7:0]  r_pri [DEPTH];
    logic signed [31:0] n_val [DEPTH];
    logic        [7:0]  n_pri [DEPTH];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_strobe;
    t_sspq_out          r_result;
    t_sspq_out          n_result;
    logic [DEPTH-1:0]   le;
    logic [DEPTH-1:0]   le_prev;
    logic               full;
    logic               empty;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    // cells holding an entry that stays ahead of the new item form a prefix
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            le[i] = (CNT_W'(i) < r_count) && (r_pri[i] <= r_item.item_priority);
        end
        le_prev[0] = 1'b1;
        for (int i = 1; i < DEPTH; i++) begin
            le_prev[i] = le[i-1];
        end
    end

    always_comb begin
        n_count = r_count;
        n_result.error_code = ERR_OK;
        for (int i = 0; i < DEPTH; i++) begin
            n_val[i] = r_val[i];
            n_pri[i] = r_pri[i];
        end
        case (r_item.cmd)
            CMD_PUSH: begin
                if (full) begin
                    n_result.error_code = ERR_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    // keep, insert, or take the entry one cell ahead
                    if (!le[0]) begin
                        n_val[0] = r_item.item_value;
                        n_pri[0] = r_item.item_priority;
                    end
                    for (int i = 1; i < DEPTH; i++) begin
                        if (!le[i]) begin
                            if (le_prev[i]) begin
                                n_val[i] = r_item.item_value;
                                n_pri[i] = r_item.item_priority;
                            end else begin
                                n_val[i] = r_val[i-1];
                                n_pri[i] = r_pri[i-1];
                            end
                        end
                    end
                end
            end
            default: begin
                if (empty) begin
                    n_result.error_code = ERR_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        n_val[i] = r_val[i+1];
                        n_pri[i] = r_pri[i+1];
                    end
                end
            end
        endcase
        n_result.queue_empty = (n_count == '0);
        n_result.front_value = (n_count == '0) ? 32'sd0 : n_val[0];
        n_result.entry_count = EC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_item <= i_item;
        end
        if (i_ctrl.exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_val[i] <= n_val[i];
                r_pri[i] <= n_pri[i];
            end
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctrl.exec;
            if (i_ctrl.exec) begin
                r_count <= n_count;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_result.queue_empty == (r_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.error_code == ERR_EMPTY) |->
            (r_result.queue_empty && r_result.front_value == 32'sd0))
        else $error("pop on empty reported a non-empty queue");

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.error_code == ERR_FULL) |->
            (r_result.entry_count == EC_W'(DEPTH)))
        else $error("dropped push reported a count other than full");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctrl.exec |=> $stable(r_count))
        else $error("entry count changed outside execution");

endmodule

FILE: hdl/stable_sorted_priority_queue.sv
`timescale 1ns / 1ps

// Channel   Ports                    Transaction
// command   start, busy, i_item      accepted at edge with start high, busy low
// result    o_strobe, o_result       one cycle per strobe, always taken
//
// Each command proceeds in order: the command is latched on acceptance, the
// sorted cell array shifts and compares in parallel in the next cycle, and
// the result is presented with o_strobe in the cycle after that, which can
// overlap the next accepted command. Reset (synchronous, active low) empties
// the queue; stored entries are not cleared. The result side cannot stall.

module stable_sorted_priority_queue
    import sspq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_sspq_in  i_item,
    output logic      o_strobe,
    output t_sspq_out o_result
);

    t_sspq_ctrl ctrl;

    sspq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_ctrl  (ctrl)
    );

    sspq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sspq_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 400;

    typedef struct {
        t_sspq_in    op;
        int unsigned gap_after;
        bit          drain_first;
    } t_pending_cmd;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_sspq_in  i_item = '0;
    logic      o_strobe;
    t_sspq_out o_result;

    t_pending_cmd pending_cmds[$];
    t_sspq_out    expected_reports[$];

    // shadow copy of the sorted store, front at index 0
    logic signed [31:0] model_value [DEPTH];
    logic        [7:0]  model_prio  [DEPTH];
    int                 model_count = 0;

    int n_errors = 0;
    int n_accepted = 0;
    int n_results = 0;
    int gap_left = 0;
    int idle_cycles = 0;

    stable_sorted_priority_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    // Apply one command to the shadow queue and return the report it produces.
    function automatic t_sspq_out next_queue_report(input t_sspq_in op);
        t_sspq_out rpt;
        int        pos;
        int        i;
        rpt.error_code = ERR_OK;
        if (op.cmd == CMD_PUSH) begin
            if (model_count >= DEPTH) begin
                rpt.error_code = ERR_FULL;
            end else begin
                pos = 0;
                // insert behind every entry of equal or smaller priority
                while (pos < model_count && model_prio[pos] <= op.item_priority)
                    pos++;
                for (i = model_count; i > pos; i--) begin
                    model_value[i] = model_value[i - 1];
                    model_prio[i]  = model_prio[i - 1];
                end
                model_value[pos] = op.item_value;
                model_prio[pos]  = op.item_priority;
                model_count++;
            end
        end else begin
            if (model_count == 0) begin
                rpt.error_code = ERR_EMPTY;
            end else begin
                for (i = 1; i < model_count; i++) begin
                    model_value[i - 1] = model_value[i];
                    model_prio[i - 1]  = model_prio[i];
                end
                model_count--;
            end
        end
        rpt.front_value = (model_count > 0) ? model_value[0] : '0;
        rpt.queue_empty = (model_count == 0);
        rpt.entry_count = EC_W'(model_count);
        return rpt;
    endfunction

    // Driver: record accepted commands, then issue the next one after its gap.
    always @(posedge i_clk) begin
        t_pending_cmd nxt;
        int           in_flight;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_reports.push_back(next_queue_report(i_item));
                n_accepted++;
            end
            if (!start || !busy) begin
                // results still owed once this edge's strobe is taken
                in_flight = n_accepted - n_results - int'(o_strobe === 1'b1);
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_cmds.size() != 0 &&
                             (!pending_cmds[0].drain_first || in_flight == 0)) begin
                    nxt = pending_cmds.pop_front();
                    i_item   <= nxt.op;
                    start    <= 1'b1;
                    gap_left = nxt.gap_after;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobe is one transaction, checked against the oldest report.
    always @(posedge i_clk) begin
        t_sspq_out want;
        if (i_rst_n && o_strobe === 1'b1) begin
            n_results <= n_results + 1;
            if (expected_reports.size() == 0) begin
                report_mismatch("result strobe with no command outstanding");
            end else begin
                want = expected_reports.pop_front();
                if (o_result.front_value !== want.front_value)
                    report_mismatch($sformatf("front_value got %0d want %0d",
                        o_result.front_value, want.front_value));
                if (o_result.queue_empty !== want.queue_empty)
                    report_mismatch($sformatf("queue_empty got %0b want %0b",
                        o_result.queue_empty, want.queue_empty));
                if (o_result.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count got %0d want %0d",
                        o_result.entry_count, want.entry_count));
                if (o_result.error_code !== want.error_code)
                    report_mismatch($sformatf("error_code got %0d want %0d",
                        o_result.error_code, want.error_code));
            end
        end
    end

    // Watchdog: stop when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe === 1'b1)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_pending_cmd make_cmd(input logic cmd, input logic [31:0] value,
                                              input logic [7:0] prio,
                                              input int unsigned gap);
        t_pending_cmd pc;
        pc.op.cmd           = cmd;
        pc.op.item_value    = value;
        pc.op.item_priority = prio;
        pc.gap_after        = gap;
        pc.drain_first      = 1'b0;
        return pc;
    endfunction

    initial begin
        t_pending_cmd pc;
        int unsigned  phase_len;
        int unsigned  push_pct;
        int unsigned  prio_hi;
        bit           burst;
        int           n;
        int           k;

        // directed: empty pop, fill with extremes and ties, full push, partial drain
        pending_cmds.push_back(make_cmd(CMD_POP, $urandom(), 8'($urandom_range(0, 255)), 0));
        pending_cmds.push_back(make_cmd(CMD_PUSH, 32'h7FFF_FFFF, 8'd255, 1));
        pending_cmds.push_back(make_cmd(CMD_PUSH, 32'h8000_0000, 8'd0, 0));
        pending_cmds.push_back(make_cmd(CMD_PUSH, 32'h0000_0000, 8'd0, 2));
        pending_cmds.push_back(make_cmd(CMD_PUSH, 32'hFFFF_FFFF, 8'd255, 0));
        for (k = 0; k < 12; k++)
            pending_cmds.push_back(make_cmd(CMD_PUSH, 32'h1000 + k,
                                            (k % 3 == 0) ? 8'd128 : 8'(k * 21), k % 4));
        pending_cmds.push_back(make_cmd(CMD_PUSH, 32'h5A5A_A5A5, 8'd0, 0));
        for (k = 0; k < 7; k++)
            pending_cmds.push_back(make_cmd(CMD_POP, $urandom(),
                                            8'($urandom_range(0, 255)), k % 3));

        // random: phases that lean toward filling, draining or neither
        n = 0;
        while (n < 1300) begin
            phase_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0: push_pct = 75;
                1: push_pct = 25;
                default: push_pct = 50;
            endcase
            // narrow priorities give many ties
            prio_hi = ($urandom_range(0, 1) != 0) ? 3 : 255;
            burst   = ($urandom_range(0, 3) == 0);
            for (k = 0; k < phase_len; k++) begin
                pc = make_cmd(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP,
                              $urandom(), 8'($urandom_range(0, prio_hi)),
                              burst ? 0 : $urandom_range(0, 4));
                // hold off until the queue has reported everything
                pc.drain_first = (k == 0) && (n == 0 || $urandom_range(0, 2) == 0);
                pending_cmds.push_back(pc);
                n++;
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (pending_cmds.size() != 0 || start || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (expected_reports.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_reports.size()));

        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
